// ----- rtl/core/stc_pkg.sv -----
// Shared types and constants for the shell command tokenizer
package stc_pkg;

    localparam int KIND_W   = 2;
    localparam int CHAR_W   = 8;
    localparam int IDX_W    = 10;
    localparam int OPC_W    = 5;
    localparam int NUM_W    = 7;
    localparam int Q_DEPTH  = 2;

    localparam logic [KIND_W-1:0] KIND_CHAR   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLOSE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

    // context flag bit positions
    localparam int F_SQ      = 0;
    localparam int F_DQ      = 1;
    localparam int F_BQ      = 2;
    localparam int F_MATH    = 3;
    localparam int F_ASSIGN  = 4;
    localparam int F_HOME    = 5;
    localparam int F_GLOB    = 6;
    localparam int F_COMMENT = 7;
    localparam int F_DOLLAR  = 8;

    typedef enum logic [OPC_W-1:0] {
        OP_NONE, OP_CONST, OP_VAR, OP_PIPE, OP_GT, OP_LT, OP_AMP, OP_ADD, OP_SUB,
        OP_MUL, OP_DIV, OP_MOD, OP_RPAR, OP_HOME, OP_APPEND, OP_ERR, OP_BOTH, OP_AND,
        OP_OR, OP_EXP, OP_SUBST, OP_ERRAPP, OP_BOTHAP, OP_KW_TRUE, OP_KW_FALSE,
        OP_GLOB, OP_ASSIGN
    } t_opcode;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] char_value;
        logic [IDX_W-1:0]  char_index;
        logic [OPC_W-1:0]  opcode;
        logic [IDX_W-1:0]  length;
        logic [NUM_W-1:0]  number;
        logic              line_end;
    } t_result;

endpackage

// ----- rtl/core/stc_ifs.sv -----
// Valid/ready channel interfaces for the byte input and the result output
interface stc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;
    modport source (output valid, byte_value, last_byte, input ready);
    modport sink   (input valid, byte_value, last_byte, output ready);
endinterface

interface stc_out_if;
    logic                          valid;
    logic                          ready;
    logic [stc_pkg::KIND_W-1:0]    result_kind;
    logic [stc_pkg::CHAR_W-1:0]    char_value;
    logic [stc_pkg::IDX_W-1:0]     char_index;
    logic [stc_pkg::OPC_W-1:0]     token_opcode;
    logic [stc_pkg::IDX_W-1:0]     token_length;
    logic [stc_pkg::NUM_W-1:0]     token_number;
    logic                          line_end;
    modport source (output valid, result_kind, char_value, char_index, token_opcode,
                    token_length, token_number, line_end, input ready);
    modport sink   (input valid, result_kind, char_value, char_index, token_opcode,
                    token_length, token_number, line_end, output ready);
endinterface

// ----- rtl/core/stc_front.sv -----
// Front end: context tracking, byte classification and token close decisions
module stc_front #(
    parameter int MAX_LINE_BYTES = 1024,
    parameter int TOKEN_LIMIT    = 128
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    stc_in_if.sink           i_in,
    input  logic             i_full,
    output logic             o_push,
    output stc_pkg::t_result o_push_data
);
    import stc_pkg::*;

    localparam int LW  = $clog2(MAX_LINE_BYTES);
    localparam int TW  = $clog2(TOKEN_LIMIT);
    localparam int LXW = (LW > IDX_W) ? LW : IDX_W;
    localparam int TXW = (TW > NUM_W) ? TW : NUM_W;

    typedef enum logic [1:0] {ACT_DROP, ACT_APPEND, ACT_CLOSE} t_act;

    logic [8:0]    r_flags, n_flags;
    logic          r_prev_dollar, n_prev_dollar;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_pos, n_pos;
    logic [TW-1:0] r_tok, n_tok;
    logic          r_rejected, n_rejected;
    logic [7:0]    r_head [0:4];

    logic          accept;
    logic          head_we;
    t_result       res;
    logic          res_valid;

    logic [7:0]     b;
    logic           last;
    logic [8:0]     v_flags;
    t_act           act;
    logic [OPC_W-1:0] match_op;
    logic [OPC_W-1:0] close_op;
    logic [LXW-1:0] len_ext;
    logic [TXW-1:0] tok_ext;

    assign accept      = i_in.valid && i_in.ready;
    assign i_in.ready  = !i_full;
    assign b           = i_in.byte_value;
    assign last        = i_in.last_byte;
    assign len_ext     = LXW'(r_len);
    assign tok_ext     = TXW'(r_tok);

    // operator and literal match on the head bytes of the open token
    always_comb begin
        match_op = (r_head[0] == "$") ? OP_VAR : OP_CONST;
        if (r_len == '0) begin
            match_op = OP_NONE;
        end else if (r_len == LW'(1)) begin
            case (r_head[0])
                "|":     match_op = OP_PIPE;
                ">":     match_op = OP_GT;
                "<":     match_op = OP_LT;
                "&":     match_op = OP_AMP;
                "+":     match_op = OP_ADD;
                "-":     match_op = OP_SUB;
                "*":     match_op = OP_MUL;
                "/":     match_op = OP_DIV;
                "%":     match_op = OP_MOD;
                ")":     match_op = OP_RPAR;
                "~":     match_op = OP_HOME;
                default: match_op = OP_CONST;
            endcase
        end else if (r_len == LW'(2)) begin
            case ({r_head[0], r_head[1]})
                ">>":    match_op = OP_APPEND;
                "2>":    match_op = OP_ERR;
                "&>":    match_op = OP_BOTH;
                "&&":    match_op = OP_AND;
                "||":    match_op = OP_OR;
                "**":    match_op = OP_EXP;
                "$(":    match_op = OP_SUBST;
                default: match_op = OP_CONST;
            endcase
        end else if (r_len == LW'(3)) begin
            if ({r_head[0], r_head[1], r_head[2]} == "2>>") begin
                match_op = OP_ERRAPP;
            end else if ({r_head[0], r_head[1], r_head[2]} == "&>>") begin
                match_op = OP_BOTHAP;
            end else begin
                match_op = OP_CONST;
            end
        end else if (r_len == LW'(4) &&
                     {r_head[0], r_head[1], r_head[2], r_head[3]} == "true") begin
            match_op = OP_KW_TRUE;
        end else if (r_len == LW'(5) &&
                     {r_head[0], r_head[1], r_head[2], r_head[3], r_head[4]} == "false") begin
            match_op = OP_KW_FALSE;
        end
    end

    always_comb begin
        n_flags       = r_flags;
        n_prev_dollar = r_prev_dollar;
        n_len         = r_len;
        n_pos         = r_pos;
        n_tok         = r_tok;
        n_rejected    = r_rejected;
        head_we       = 1'b0;
        res_valid     = 1'b0;
        res           = '0;
        v_flags       = r_flags;
        act           = ACT_APPEND;
        close_op      = match_op;

        if (accept) begin
            if (r_rejected) begin
                if (last) begin
                    n_rejected = 1'b0;
                    n_flags = '0; n_prev_dollar = 1'b0; n_len = '0; n_tok = '0; n_pos = '0;
                end
            end else if ((r_pos == '0 && last) || r_tok == TW'(TOKEN_LIMIT - 1) ||
                         (r_pos >= LW'(MAX_LINE_BYTES - 1) && !last)) begin
                res_valid    = 1'b1;
                res.kind     = KIND_REJECT;
                res.line_end = 1'b1;
                if (last) begin
                    n_flags = '0; n_prev_dollar = 1'b0; n_len = '0; n_tok = '0; n_pos = '0;
                end else begin
                    n_rejected = 1'b1;
                end
            end else if (r_pos >= LW'(MAX_LINE_BYTES - 1)) begin
                n_flags = '0; n_prev_dollar = 1'b0; n_len = '0; n_tok = '0; n_pos = '0;
            end else begin
                if (r_prev_dollar && b == "(") v_flags[F_DOLLAR] = 1'b1;
                n_prev_dollar = (b == "$") && !v_flags[F_DOLLAR] && !last;
                n_pos = r_pos + LW'(1);

                case (b)
                    8'h22: begin v_flags[F_DQ] = !v_flags[F_DQ]; act = ACT_DROP; end
                    8'h27: begin v_flags[F_SQ] = !v_flags[F_SQ]; act = ACT_DROP; end
                    8'h60: begin v_flags[F_BQ] = !v_flags[F_BQ]; act = ACT_DROP; end
                    "(": begin
                        if (v_flags[F_DOLLAR] && !v_flags[F_MATH]) begin
                            v_flags[F_MATH]   = 1'b1;
                            v_flags[F_DOLLAR] = 1'b0;
                        end
                    end
                    ")": v_flags[F_MATH] = 1'b0;
                    "*": if (!v_flags[F_MATH]) v_flags[F_GLOB] = 1'b1;
                    "?": v_flags[F_GLOB] = 1'b1;
                    "=": v_flags[F_ASSIGN] = 1'b1;
                    "#": begin v_flags[F_COMMENT] = 1'b1; act = ACT_DROP; end
                    "~": v_flags[F_HOME] = 1'b1;
                    8'h20, 8'h0D, 8'h0A, 8'h00: begin
                        if (v_flags[F_COMMENT] && b != 8'h0A) begin
                            act = ACT_DROP;
                        end else if (v_flags == '0 || v_flags[F_MATH] || v_flags[F_ASSIGN] ||
                                     v_flags[F_GLOB] || v_flags[F_HOME]) begin
                            act = ACT_CLOSE;
                        end
                    end
                    default: ;
                endcase

                if (act == ACT_APPEND) begin
                    res_valid       = 1'b1;
                    res.kind        = KIND_CHAR;
                    res.char_value  = b;
                    res.char_index  = len_ext[IDX_W-1:0];
                    res.line_end    = last;
                    head_we         = (r_len < LW'(5));
                    n_len           = r_len + LW'(1);
                end else if (act == ACT_CLOSE) begin
                    if (v_flags[F_HOME]) begin
                        close_op = OP_HOME;   v_flags[F_HOME] = 1'b0;
                    end else if (v_flags[F_GLOB]) begin
                        close_op = OP_GLOB;   v_flags[F_GLOB] = 1'b0;
                    end else if (v_flags[F_ASSIGN]) begin
                        close_op = OP_ASSIGN; v_flags[F_ASSIGN] = 1'b0;
                    end
                    res_valid    = 1'b1;
                    res.kind     = KIND_CLOSE;
                    res.opcode   = close_op;
                    res.length   = len_ext[IDX_W-1:0];
                    res.number   = tok_ext[NUM_W-1:0];
                    res.line_end = last;
                    n_tok        = r_tok + TW'(1);
                    n_len        = '0;
                end
                n_flags = v_flags;
                if (last) begin
                    n_flags = '0; n_prev_dollar = 1'b0; n_len = '0; n_tok = '0; n_pos = '0;
                end
            end
        end
    end

    assign o_push      = res_valid;
    assign o_push_data = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags       <= '0;
            r_prev_dollar <= 1'b0;
            r_len         <= '0;
            r_pos         <= '0;
            r_tok         <= '0;
            r_rejected    <= 1'b0;
        end else begin
            r_flags       <= n_flags;
            r_prev_dollar <= n_prev_dollar;
            r_len         <= n_len;
            r_pos         <= n_pos;
            r_tok         <= n_tok;
            r_rejected    <= n_rejected;
        end
    end

    always_ff @(posedge i_clk) begin
        if (head_we) r_head[r_len[2:0]] <= b;
    end

endmodule

// ----- rtl/core/stc_queue.sv -----
// Short result queue between the front end and the output stage
module stc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  stc_pkg::t_result i_push_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output stc_pkg::t_result o_data
);
    import stc_pkg::*;

    localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW  = $clog2(Q_DEPTH + 1);

    t_result        r_mem [0:Q_DEPTH-1];
    logic [QAW-1:0] r_wr, n_wr;
    logic [QAW-1:0] r_rd, n_rd;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == CW'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) n_wr = (r_wr == QAW'(Q_DEPTH - 1)) ? '0 : r_wr + QAW'(1);
        if (do_pop)  n_rd = (r_rd == QAW'(Q_DEPTH - 1)) ? '0 : r_rd + QAW'(1);
        if (do_push && !do_pop)      n_cnt = r_cnt + CW'(1);
        else if (do_pop && !do_push) n_cnt = r_cnt - CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_push_data;
    end

endmodule

// ----- rtl/core/stc_back.sv -----
// Back end: result formatting and the registered output transfer
module stc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  stc_pkg::t_result i_q_data,
    output logic             o_pop,
    stc_out_if.source        o_out
);
    import stc_pkg::*;

    logic    r_valid;
    t_result r_data;
    t_result fmt;

    assign o_pop = i_q_valid && (!r_valid || o_out.ready);

    // fields that do not belong to the result kind read as zero
    always_comb begin
        fmt          = '0;
        fmt.kind     = i_q_data.kind;
        fmt.line_end = i_q_data.line_end;
        case (i_q_data.kind)
            KIND_CHAR: begin
                fmt.char_value = i_q_data.char_value;
                fmt.char_index = i_q_data.char_index;
            end
            KIND_CLOSE: begin
                fmt.opcode = i_q_data.opcode;
                fmt.length = i_q_data.length;
                fmt.number = i_q_data.number;
            end
            default: fmt.line_end = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || o_out.ready) begin
            r_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_data <= fmt;
    end

    assign o_out.valid        = r_valid;
    assign o_out.result_kind  = r_data.kind;
    assign o_out.char_value   = r_data.char_value;
    assign o_out.char_index   = r_data.char_index;
    assign o_out.token_opcode = r_data.opcode;
    assign o_out.token_length = r_data.length;
    assign o_out.token_number = r_data.number;
    assign o_out.line_end     = r_data.line_end;

endmodule

// ----- rtl/core/shell_command_tokenizer.sv -----
// Shell command tokenizer top level
// Usage:
//   i_in takes one command-line byte per transfer, with last_byte marking the
//   line's final byte. o_out gives at most one result per byte: a token
//   character, a closed token with its opcode, length and number, or a
//   rejection of the line.
// Timing:
//   One byte per cycle sustained while the queue is not full. A result is
//   written to the queue on its byte's transfer edge and passes through the
//   output register before it is presented on o_out. The front end updates
//   all context in the cycle of the transfer.
// Stall:
//   A two-entry queue and the output register sit between the front end and
//   o_out. When o_out.ready is low, results collect there and i_in.ready drops
//   once the queue is full; nothing is lost.
// Reset:
//   i_rst_n clears the context, counters and queue; the next byte starts a
//   fresh line. Bytes that yield no result (quotes, comment marks) still
//   take one transfer each.
module shell_command_tokenizer #(
    parameter int MAX_LINE_BYTES = 1024,
    parameter int TOKEN_LIMIT    = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    stc_in_if.sink    i_in,
    stc_out_if.source o_out
);
    import stc_pkg::*;

    logic    push, full, pop, q_valid;
    t_result push_data, q_data;

    stc_front #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES),
        .TOKEN_LIMIT    (TOKEN_LIMIT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_full      (full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    stc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (full),
        .i_pop       (pop),
        .o_valid     (q_valid),
        .o_data      (q_data)
    );

    stc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule
